// ===== rtl/eihp_pkg.sv =====
`timescale 1ns / 1ps
package eihp_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [1:0]  proto_class;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] icmp_type_code;
    logic [7:0]  ip_ttl;
    logic [7:0]  payload_start;
    logic [15:0] payload_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_UNSUPP    = 3'd2,
    ST_BAD_IPV4  = 3'd3,
    ST_BAD_L4    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PC_UNKNOWN = 2'd0,
    PC_TCP     = 2'd1,
    PC_UDP     = 2'd2,
    PC_ICMP    = 2'd3
  } proto_class_e;

  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [15:0] EtypeIpv4   = 16'h0800;
  localparam logic [15:0] EthLen      = 16'd14;
  localparam logic [15:0] IpMinEnd    = 16'd34;

  // Snapshot of one frame's captured state, handed from front to back.
  typedef struct packed {
    logic [15:0] len;
    logic [3:0]  ihl;
    logic [3:0]  ver;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [3:0]  doff;
    logic [15:0] udp_len;
    logic [15:0] etype;
    logic [7:0]  ttl;
    logic [63:0] addrs;
    logic [31:0] l4_words;
    logic [5:0]  flags;
  } frame_snap_t;

endpackage

// ===== rtl/eihp_capture.sv =====
`timescale 1ns / 1ps
module eihp_capture import eihp_pkg::*; #(
  parameter int unsigned MaxFrameBytes = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  in_item_t    item_i,
  output logic        snap_valid_o,
  output frame_snap_t snap_o
);

  localparam logic [15:0] MaxLen = 16'(MaxFrameBytes);

  frame_snap_t st_q, st_d;
  logic [15:0] p, t, r;
  logic [7:0]  b;

  always_comb begin
    st_d = st_q;
    p = st_q.len;
    b = item_i.frame_byte;
    t = EthLen + {10'd0, st_q.ihl, 2'b00};
    r = p - t;
    if (p < MaxLen) begin
      st_d.len = p + 16'd1;
      unique case (p)
        16'd12: st_d.etype[15:8] = b;
        16'd13: st_d.etype[7:0] = b;
        16'd14: begin
          st_d.ver = b[7:4];
          st_d.ihl = b[3:0];
        end
        16'd16: st_d.total_len[15:8] = b;
        16'd17: st_d.total_len[7:0] = b;
        16'd22: st_d.ttl = b;
        16'd23: st_d.proto = b;
        16'd26: st_d.addrs[63:56] = b;
        16'd27: st_d.addrs[55:48] = b;
        16'd28: st_d.addrs[47:40] = b;
        16'd29: st_d.addrs[39:32] = b;
        16'd30: st_d.addrs[31:24] = b;
        16'd31: st_d.addrs[23:16] = b;
        16'd32: st_d.addrs[15:8] = b;
        16'd33: st_d.addrs[7:0] = b;
        default: ;
      endcase
      if (p >= IpMinEnd && p >= t && r < 16'd14) begin
        unique case (r[3:0])
          4'd0: st_d.l4_words[31:24] = b;
          4'd1: st_d.l4_words[23:16] = b;
          4'd2: st_d.l4_words[15:8] = b;
          4'd3: st_d.l4_words[7:0] = b;
          4'd4: st_d.udp_len[15:8] = b;
          4'd5: st_d.udp_len[7:0] = b;
          4'd12: st_d.doff = b[7:4];
          4'd13: st_d.flags = b[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      snap_valid_o <= 1'b0;
    end else begin
      snap_valid_o <= acc_i && item_i.end_of_frame;
      if (acc_i) begin
        st_q <= item_i.end_of_frame ? '0 : st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) snap_o <= st_d;
  end

endmodule

// ===== rtl/eihp_fifo.sv =====
`timescale 1ns / 1ps
module eihp_fifo import eihp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_snap_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output frame_snap_t data_o
);

  frame_snap_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q >= 3'd2;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

endmodule

// ===== rtl/eihp_check.sv =====
`timescale 1ns / 1ps
module eihp_check import eihp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  frame_snap_t snap_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_o
);

  out_item_t res;
  logic [15:0] len, t, hl, ps, ihl4, doff4;
  logic ip_seen;

  always_comb begin
    res = '0;
    len = snap_i.len;
    ihl4 = {10'd0, snap_i.ihl, 2'b00};
    doff4 = {10'd0, snap_i.doff, 2'b00};
    t = EthLen + ihl4;
    hl = '0;
    ip_seen = 1'b0;
    res.ether_type = snap_i.etype;
    if (len < EthLen) begin
      res.parse_status = ST_TRUNCATED;
      res.ether_type = '0;
    end else if (snap_i.etype != EtypeIpv4) begin
      res.parse_status = ST_UNSUPP;
    end else if (len < IpMinEnd) begin
      res.parse_status = ST_TRUNCATED;
    end else if (snap_i.ver != 4'd4 || snap_i.ihl < 4'd5) begin
      res.parse_status = ST_BAD_IPV4;
    end else if (len < t) begin
      res.parse_status = ST_TRUNCATED;
    end else begin
      ip_seen = 1'b1;
      if (snap_i.total_len < ihl4) begin
        res.parse_status = ST_BAD_IPV4;
      end else if (snap_i.proto == ProtoTcp) begin
        res.proto_class = PC_TCP;
        if (len < t + 16'd20) res.parse_status = ST_TRUNCATED;
        else if (snap_i.doff < 4'd5) res.parse_status = ST_BAD_L4;
        else if (len < t + doff4) res.parse_status = ST_TRUNCATED;
        else begin
          hl = doff4;
          res.source_port = snap_i.l4_words[31:16];
          res.dest_port = snap_i.l4_words[15:0];
          res.tcp_flag_bits = snap_i.flags;
        end
      end else if (snap_i.proto == ProtoUdp) begin
        res.proto_class = PC_UDP;
        if (len < t + 16'd8) res.parse_status = ST_TRUNCATED;
        else begin
          res.source_port = snap_i.l4_words[31:16];
          res.dest_port = snap_i.l4_words[15:0];
          if (snap_i.udp_len < 16'd8) res.parse_status = ST_BAD_L4;
          else hl = 16'd8;
        end
      end else if (snap_i.proto == ProtoIcmp) begin
        res.proto_class = PC_ICMP;
        if (len < t + 16'd8) res.parse_status = ST_TRUNCATED;
        else begin
          res.icmp_type_code = snap_i.l4_words[31:16];
          hl = 16'd8;
        end
      end else begin
        res.parse_status = ST_UNSUPP;
      end
    end
    if (ip_seen) begin
      res.src_addr = snap_i.addrs[63:32];
      res.dst_addr = snap_i.addrs[31:0];
      res.ip_ttl = snap_i.ttl;
    end
    ps = t + hl;
    if (res.parse_status == ST_OK) begin
      res.payload_start = ps[7:0];
      res.payload_bytes = (len > ps) ? len - ps : 16'd0;
    end
  end

  assign pop_o = valid_i && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || !out_stall_i) begin
      out_valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_o <= res;
  end

endmodule

// ===== rtl/eth_ipv4_l4_header_parser.sv =====
`timescale 1ns / 1ps
// Ethernet/IPv4/L4 header parser.
// The input channel carries one frame byte per item with an end-of-frame
// flag; the output channel carries one header summary per frame.
// A capture front end takes one byte per cycle and, on the last byte,
// registers a snapshot of the captured fields into a four-entry queue.
// A check stage pops the queue, evaluates the status checks combinationally
// and holds the result in an output register until it is taken.
// The result reaches the output through the snapshot register, the queue and the output register.
// Throughput is one byte per cycle while the input is not stalled; frames of
// one byte each still flow at one per cycle while the receiver keeps up.
// When the receiver stalls, results wait in the queue; the input stalls
// only once two snapshots are queued, which leaves room for those in
// flight.
// Reset clears the byte counter, all captured fields and the queue.
module eth_ipv4_l4_header_parser import eihp_pkg::*; #(
  parameter int unsigned MaxFrameBytes = 16384
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic        acc, snap_valid, q_full, q_valid, pop;
  frame_snap_t snap, q_data;

  assign in_stall_o = q_full;
  assign acc = in_valid_i && !in_stall_o;

  eihp_capture #(.MaxFrameBytes(MaxFrameBytes)) u_cap (
    .clk_i, .rst_ni, .acc_i(acc), .item_i(in_item_i),
    .snap_valid_o(snap_valid), .snap_o(snap)
  );

  eihp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(snap_valid), .data_i(snap), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_data)
  );

  eihp_check u_chk (
    .clk_i, .rst_ni, .valid_i(q_valid), .snap_i(q_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_o(out_item_o)
  );

  a_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped under stall");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.parse_status <= ST_BAD_L4)
    else $error("bad status");
  a_pstart_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.parse_status != ST_OK |-> out_item_o.payload_start == 8'd0)
    else $error("payload start set on error");

endmodule

// ===== tb/sv/tb_eth_ipv4_l4_header_parser.sv =====
`timescale 1ns / 1ps
module tb_eth_ipv4_l4_header_parser;
  import eihp_pkg::*;

  localparam int unsigned MaxBytes = 16384;
  localparam int unsigned StallLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  eth_ipv4_l4_header_parser uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  in_item_t  byte_queue[$];
  out_item_t summary_queue[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_sender = 0;
  int        quiet_cycles = 0;

  // Parser state mirrored from the block.
  logic [15:0] f_count;
  logic [3:0]  f_ihl;
  logic [3:0]  f_ver;
  logic [15:0] f_total;
  logic [7:0]  f_proto;
  logic [3:0]  f_doff;
  logic [15:0] f_udplen;
  logic [15:0] f_etype;
  logic [7:0]  f_ttl;
  logic [63:0] f_addrs;
  logic [31:0] f_l4;
  logic [5:0]  f_flags;

  task automatic clear_frame_state();
    f_count = '0; f_ihl = '0; f_ver = '0; f_total = '0; f_proto = '0;
    f_doff = '0; f_udplen = '0; f_etype = '0; f_ttl = '0; f_addrs = '0;
    f_l4 = '0; f_flags = '0;
  endtask

  task automatic absorb_byte(input in_item_t it);
    int unsigned p;
    int unsigned t;
    int unsigned r;
    int unsigned len;
    int unsigned hl;
    out_item_t   s;
    p = f_count;
    t = 14 + 4 * f_ihl;
    if (p < MaxBytes) begin
      case (p)
        12: f_etype[15:8] = it.frame_byte;
        13: f_etype[7:0] = it.frame_byte;
        14: begin
          f_ver = it.frame_byte[7:4];
          f_ihl = it.frame_byte[3:0];
        end
        16: f_total[15:8] = it.frame_byte;
        17: f_total[7:0] = it.frame_byte;
        22: f_ttl = it.frame_byte;
        23: f_proto = it.frame_byte;
        default: begin
          if (p >= 26 && p <= 33) f_addrs[(33 - p) * 8 +: 8] = it.frame_byte;
        end
      endcase
      if (p >= 34 && p >= t && p - t < 14) begin
        r = p - t;
        if (r <= 3) f_l4[(3 - r) * 8 +: 8] = it.frame_byte;
        else if (r == 4) f_udplen[15:8] = it.frame_byte;
        else if (r == 5) f_udplen[7:0] = it.frame_byte;
        else if (r == 12) f_doff = it.frame_byte[7:4];
        else if (r == 13) f_flags = it.frame_byte[5:0];
      end
      f_count = f_count + 16'd1;
    end
    if (!it.end_of_frame) return;
    len = f_count;
    t = 14 + 4 * f_ihl;
    hl = 0;
    s = '0;
    s.parse_status = ST_OK;
    s.proto_class = PC_UNKNOWN;
    s.ether_type = f_etype;
    if (len < 14) begin
      s.parse_status = ST_TRUNCATED;
      s.ether_type = '0;
    end else if (f_etype != EtypeIpv4) s.parse_status = ST_UNSUPP;
    else if (len < 34) s.parse_status = ST_TRUNCATED;
    else if (f_ver != 4 || f_ihl < 5) s.parse_status = ST_BAD_IPV4;
    else if (len < t) s.parse_status = ST_TRUNCATED;
    else begin
      s.src_addr = f_addrs[63:32];
      s.dst_addr = f_addrs[31:0];
      s.ip_ttl = f_ttl;
      if (f_total < 4 * f_ihl) s.parse_status = ST_BAD_IPV4;
      else if (f_proto == ProtoTcp) begin
        s.proto_class = PC_TCP;
        if (len < t + 20) s.parse_status = ST_TRUNCATED;
        else if (f_doff < 5) s.parse_status = ST_BAD_L4;
        else if (len < t + 4 * f_doff) s.parse_status = ST_TRUNCATED;
        else begin
          hl = 4 * f_doff;
          s.source_port = f_l4[31:16];
          s.dest_port = f_l4[15:0];
          s.tcp_flag_bits = f_flags;
        end
      end else if (f_proto == ProtoUdp) begin
        s.proto_class = PC_UDP;
        if (len < t + 8) s.parse_status = ST_TRUNCATED;
        else begin
          s.source_port = f_l4[31:16];
          s.dest_port = f_l4[15:0];
          if (f_udplen < 8) s.parse_status = ST_BAD_L4;
          else hl = 8;
        end
      end else if (f_proto == ProtoIcmp) begin
        s.proto_class = PC_ICMP;
        if (len < t + 8) s.parse_status = ST_TRUNCATED;
        else begin
          s.icmp_type_code = f_l4[31:16];
          hl = 8;
        end
      end else s.parse_status = ST_UNSUPP;
    end
    if (s.parse_status == ST_OK) begin
      s.payload_start = 8'(t + hl);
      s.payload_bytes = (len > t + hl) ? 16'(len - t - hl) : 16'd0;
    end
    summary_queue.push_back(s);
    clear_frame_state();
  endtask

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) absorb_byte(in_item_i);
    if (!rst_ni || (in_valid_i && in_stall_o)) begin
    end else if (!hold_sender && byte_queue.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      in_item_i <= byte_queue.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (summary_queue.size() == 0) begin
        $display("%0t unexpected result: got %p", $time, out_item_o);
        errors++;
      end else begin
        out_item_t e;
        e = summary_queue.pop_front();
        if (e.parse_status != out_item_o.parse_status)
          $display("%0t parse_status exp %0d got %0d", $time, e.parse_status,
                   out_item_o.parse_status);
        if (e.proto_class != out_item_o.proto_class)
          $display("%0t proto_class exp %0d got %0d", $time, e.proto_class,
                   out_item_o.proto_class);
        if (e.ether_type != out_item_o.ether_type)
          $display("%0t ether_type exp %h got %h", $time, e.ether_type,
                   out_item_o.ether_type);
        if (e.src_addr != out_item_o.src_addr)
          $display("%0t src_addr exp %h got %h", $time, e.src_addr, out_item_o.src_addr);
        if (e.dst_addr != out_item_o.dst_addr)
          $display("%0t dst_addr exp %h got %h", $time, e.dst_addr, out_item_o.dst_addr);
        if (e.source_port != out_item_o.source_port)
          $display("%0t source_port exp %h got %h", $time, e.source_port,
                   out_item_o.source_port);
        if (e.dest_port != out_item_o.dest_port)
          $display("%0t dest_port exp %h got %h", $time, e.dest_port,
                   out_item_o.dest_port);
        if (e.tcp_flag_bits != out_item_o.tcp_flag_bits)
          $display("%0t tcp_flag_bits exp %h got %h", $time, e.tcp_flag_bits,
                   out_item_o.tcp_flag_bits);
        if (e.icmp_type_code != out_item_o.icmp_type_code)
          $display("%0t icmp_type_code exp %h got %h", $time, e.icmp_type_code,
                   out_item_o.icmp_type_code);
        if (e.ip_ttl != out_item_o.ip_ttl)
          $display("%0t ip_ttl exp %h got %h", $time, e.ip_ttl, out_item_o.ip_ttl);
        if (e.payload_start != out_item_o.payload_start)
          $display("%0t payload_start exp %0d got %0d", $time, e.payload_start,
                   out_item_o.payload_start);
        if (e.payload_bytes != out_item_o.payload_bytes)
          $display("%0t payload_bytes exp %0d got %0d", $time, e.payload_bytes,
                   out_item_o.payload_bytes);
        if (e != out_item_o) errors++;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit last);
    in_item_t it;
    it.frame_byte = b;
    it.end_of_frame = last;
    byte_queue.push_back(it);
  endtask

  // Builds a frame; etype, ver_ihl, total, proto, the UDP length and doff bytes are chosen freely, the rest are random.
  task automatic push_frame(input int unsigned len, input logic [15:0] etype,
                            input logic [7:0] ver_ihl, input logic [15:0] total,
                            input logic [7:0] proto, input logic [7:0] doff,
                            input logic [15:0] udplen);
    int unsigned t;
    logic [7:0]  b;
    t = 14 + 4 * ver_ihl[3:0];
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == 12) b = etype[15:8];
      else if (i == 13) b = etype[7:0];
      else if (i == 14) b = ver_ihl;
      else if (i == 16) b = total[15:8];
      else if (i == 17) b = total[7:0];
      else if (i == 23) b = proto;
      else if (i == t + 4) b = udplen[15:8];
      else if (i == t + 5) b = udplen[7:0];
      else if (i == t + 12) b = doff;
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic push_random_frame();
    int unsigned k;
    int unsigned ihl;
    int unsigned len;
    logic [7:0]  proto;
    logic [7:0]  doff;
    k = $urandom_range(99);
    ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 5);
    case ($urandom_range(3))
      0: proto = ProtoTcp;
      1: proto = ProtoUdp;
      2: proto = ProtoIcmp;
      default: proto = 8'($urandom);
    endcase
    doff = {4'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(15, 5)),
            4'($urandom)};
    len = 14 + 4 * ihl + $urandom_range(16);
    if (k < 10) len = $urandom_range(1, 40);
    if (k < 85) begin
      push_frame(len, ($urandom_range(9) == 0) ? 16'($urandom) : EtypeIpv4,
                 {($urandom_range(9) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)},
                 ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom),
                 proto, doff,
                 ($urandom_range(5) == 0) ? 16'($urandom_range(9)) : 16'($urandom));
    end else begin
      for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || in_valid_i || summary_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_frame(13, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(14, 16'h86DD, 8'h45, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(30, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(34, EtypeIpv4, 8'h65, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(34, EtypeIpv4, 8'h44, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(34, EtypeIpv4, 8'h4F, 16'd80, ProtoTcp, 8'h50, 16'd8);
    push_frame(34, EtypeIpv4, 8'h45, 16'd19, ProtoTcp, 8'h50, 16'd8);
    push_frame(34, EtypeIpv4, 8'h45, 16'hFFFF, 8'd99, 8'h50, 16'd8);
    push_frame(50, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(54, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'h4F, 16'd8);
    push_frame(54, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'hF0, 16'd8);
    push_frame(54, EtypeIpv4, 8'h45, 16'd40, ProtoTcp, 8'h50, 16'd8);
    push_frame(40, EtypeIpv4, 8'h45, 16'd40, ProtoUdp, 8'h50, 16'd8);
    push_frame(42, EtypeIpv4, 8'h45, 16'd40, ProtoUdp, 8'h50, 16'd7);
    push_frame(42, EtypeIpv4, 8'h45, 16'd40, ProtoUdp, 8'h50, 16'd8);
    push_frame(41, EtypeIpv4, 8'h45, 16'd40, ProtoIcmp, 8'h50, 16'd8);
    push_frame(84, EtypeIpv4, 8'h4F, 16'd60, ProtoIcmp, 8'h50, 16'd8);
    push_frame(134, EtypeIpv4, 8'h4F, 16'd60, ProtoTcp, 8'hF0, 16'd8);

    send_idle_pct = 11;
    recv_idle_pct = 69;
    wait_drained();
    hold_sender = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk_i);
    hold_sender = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
      for (int n = 0; n < 2; n++) push_random_frame();
      for (int n = 0; n < 6; n++) push_byte(8'($urandom), 1'b1);
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (errors == 0 && summary_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
